FILE: rtl/bre_pkg.sv
package bre_pkg;

   localparam int CHAR_BITS      = 8;
   localparam int PEND_BITS      = 6;
   localparam int STOP_BITS      = 10;
   localparam int WIDTH_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_BLANK = 8'h20;

   localparam logic [PEND_BITS-1:0] PEND_MAX = 6'd63;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TAB_WIDTH  = 3'd1;
   localparam int                        REG_STOP_BASE  = 2;

   localparam logic [WIDTH_BITS-1:0] RESET_STOP_COUNT = 3'd0;
   localparam logic [WIDTH_BITS-1:0] RESET_TAB_WIDTH  = 3'd3;
   localparam int                    STOP_SPACING     = 8;

   // one queued job: a run of blanks followed by one closing byte
   typedef struct packed {
      logic [PEND_BITS-1:0] blanks;
      logic [CHAR_BITS-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

FILE: rtl/bre_req_if.sv
interface bre_req_if;
   logic                          valid;
   logic                          ready;
   logic [bre_pkg::CHAR_BITS-1:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

FILE: rtl/bre_rsp_if.sv
interface bre_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bre_pkg::CHAR_BITS-1:0] out_char;
   logic                          last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

FILE: rtl/bre_fifo.sv
module bre_fifo #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     pop,
   output logic [WIDTH-1:0]         rdata,
   output bre_pkg::fifo_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue read while empty");

endmodule

FILE: rtl/bre_front.sv
module bre_front #(
   parameter int NUM_STOPS   = 6,
   parameter int COLUMN_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bre_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bre_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   bre_req_if.sink                             req,
   input  bre_pkg::fifo_status_type            q_status,
   output logic                                push,
   output bre_pkg::cmd_type                    cmd
);

   localparam int CMP_BITS = (COLUMN_BITS > bre_pkg::STOP_BITS) ?
                             COLUMN_BITS : bre_pkg::STOP_BITS;
   localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

   logic [bre_pkg::WIDTH_BITS-1:0] stop_count_ff;
   logic [bre_pkg::WIDTH_BITS-1:0] tab_width_ff;
   logic [bre_pkg::STOP_BITS-1:0]  stop_ff [NUM_STOPS];

   logic [COLUMN_BITS-1:0]        column_ff, column_in;
   logic [bre_pkg::PEND_BITS-1:0] pend_ff, pend_in;

   logic                   accept;
   logic                   found;
   logic [CMP_BITS-1:0]    best;
   logic [CMP_BITS-1:0]    col_wide;
   logic [COLUMN_BITS-1:0] mask;
   logic [COLUMN_BITS:0]   dflt;
   logic [COLUMN_BITS-1:0] nxt;
   logic [COLUMN_BITS:0]   col_inc;
   logic [COLUMN_BITS-1:0] col_inc_sat;
   logic                   reach;
   logic                   is_blank, is_tab, is_nl;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign is_blank  = (req.in_char == bre_pkg::CH_BLANK);
   assign is_tab    = (req.in_char == bre_pkg::CH_TAB);
   assign is_nl     = (req.in_char == bre_pkg::CH_NL);

   // next stop: smallest enabled explicit stop above the column,
   // else the next multiple of the default spacing
   always_comb begin
      col_wide = CMP_BITS'(column_ff);
      found    = 1'b0;
      best     = '1;
      for (int i = 0; i < NUM_STOPS; i++) begin
         if (int'(stop_count_ff) > i && CMP_BITS'(stop_ff[i]) > col_wide &&
             (!found || CMP_BITS'(stop_ff[i]) < best)) begin
            best  = CMP_BITS'(stop_ff[i]);
            found = 1'b1;
         end
      end
      mask = ~(COL_MAX << tab_width_ff);
      dflt = {1'b0, column_ff | mask} + 1'b1;
      if (found) begin
         nxt = (best > CMP_BITS'(COL_MAX)) ? COL_MAX : best[COLUMN_BITS-1:0];
      end else begin
         nxt = dflt[COLUMN_BITS] ? COL_MAX : dflt[COLUMN_BITS-1:0];
      end
   end

   assign col_inc     = {1'b0, column_ff} + 1'b1;
   assign col_inc_sat = col_inc[COLUMN_BITS] ? COL_MAX : col_inc[COLUMN_BITS-1:0];
   assign reach       = (col_inc == {1'b0, nxt});

   always_comb begin
      column_in  = column_ff;
      pend_in    = pend_ff;
      push       = 1'b0;
      cmd.blanks = '0;
      cmd.ch     = req.in_char;
      if (accept) begin
         priority if (is_blank) begin
            column_in = col_inc_sat;
            if (reach) begin
               push    = 1'b1;
               cmd.ch  = bre_pkg::CH_TAB;
               pend_in = '0;
            end else if (pend_ff == bre_pkg::PEND_MAX) begin
               push    = 1'b1;
               cmd.ch  = bre_pkg::CH_BLANK;
            end else begin
               pend_in = pend_ff + 1'b1;
            end
         end else if (is_tab) begin
            push      = 1'b1;
            column_in = nxt;
            pend_in   = '0;
         end else begin
            push       = 1'b1;
            cmd.blanks = pend_ff;
            pend_in    = '0;
            column_in  = is_nl ? '0 : col_inc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         pend_ff   <= '0;
      end else begin
         column_ff <= column_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= bre_pkg::RESET_STOP_COUNT;
         tab_width_ff  <= bre_pkg::RESET_TAB_WIDTH;
         for (int i = 0; i < NUM_STOPS; i++) begin
            stop_ff[i] <= bre_pkg::STOP_BITS'(bre_pkg::STOP_SPACING * (i + 1));
         end
      end else if (csr_we) begin
         if (csr_index == bre_pkg::REG_STOP_COUNT) begin
            stop_count_ff <= csr_wdata[bre_pkg::WIDTH_BITS-1:0];
         end
         if (csr_index == bre_pkg::REG_TAB_WIDTH) begin
            tab_width_ff <= csr_wdata[bre_pkg::WIDTH_BITS-1:0];
         end
         for (int i = 0; i < NUM_STOPS; i++) begin
            if (csr_index == bre_pkg::CSR_INDEX_BITS'(bre_pkg::REG_STOP_BASE + i)) begin
               stop_ff[i] <= csr_wdata[bre_pkg::STOP_BITS-1:0];
            end
         end
      end
   end

   a_tab_drops_run: assert property (@(posedge clock) disable iff (reset)
      accept && is_tab |=> pend_ff == '0)
      else $error("held blanks survive a tab");

   a_newline_home: assert property (@(posedge clock) disable iff (reset)
      accept && is_nl |=> column_ff == '0 && pend_ff == '0)
      else $error("newline did not return to column zero");

endmodule

FILE: rtl/bre_back.sv
module bre_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bre_pkg::fifo_status_type q_status,
   input  bre_pkg::cmd_type         head,
   output logic                     pop,
   bre_rsp_if.source                rsp
);

   logic [bre_pkg::PEND_BITS-1:0] sent_ff, sent_in;
   logic                          valid_ff, valid_in;
   logic [bre_pkg::CHAR_BITS-1:0] char_ff, char_in;
   logic                          last_ff, last_in;
   logic                          load, emit, blank_phase;

   assign load        = !valid_ff || rsp.ready;
   assign emit        = load && !q_status.empty;
   assign blank_phase = (sent_ff != head.blanks);
   assign pop         = emit && !blank_phase;

   always_comb begin
      sent_in  = sent_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = emit;
      end
      if (emit) begin
         if (blank_phase) begin
            char_in = bre_pkg::CH_BLANK;
            last_in = 1'b0;
            sent_in = sent_ff + 1'b1;
         end else begin
            char_in = head.ch;
            last_in = 1'b1;
            sent_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.last     = last_ff;

   a_inner_is_blank: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff |-> char_ff == bre_pkg::CH_BLANK)
      else $error("non-final result is not a blank");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> sent_ff <= head.blanks)
      else $error("blank run overshoots its job");

endmodule

FILE: rtl/blank_run_to_tab_entab.sv
// Blank-run to tab converter with a programmable tab stop list.
//
// req  : one character byte per transfer (in_char).
// rsp  : emitted bytes (out_char); last marks the final byte that one
//        request caused. A held blank causes no response at all.
// csr  : write enable, register index and data; write only while idle.
//        0 stop count, 1 log2 default spacing, 2.. explicit stop columns.
//
// Throughput: the front takes one byte per cycle while the job queue has
// room. The back emits one byte per cycle from the output register while
// rsp.ready is high, so a byte that flushes n held blanks comes out as n
// blanks and then the byte itself; a run of up to 63 blanks is the worst
// case. The queue of QUEUE_DEPTH jobs lets the front run ahead of a flush.
// Path: a request is written into the job queue, and the back then loads
// its first response byte into the output register, which drives rsp.
// Reset: column and held blanks clear, registers return to their reset
// values, queue and output register empty. No clearing pass.
// Stall: when rsp.ready is low the output register holds, the queue fills
// and then req.ready drops; nothing is lost.
module blank_run_to_tab_entab #(
   parameter int NUM_STOPS   = 6,
   parameter int COLUMN_BITS = 10,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   bre_req_if.sink                            req,
   bre_rsp_if.source                          rsp,
   input  logic                               csr_we,
   input  logic [bre_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bre_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   bre_pkg::cmd_type         push_cmd;
   bre_pkg::cmd_type         head_cmd;
   bre_pkg::fifo_status_type q_status;
   logic                     push;
   logic                     pop;

   // front: classify each byte, advance the column, queue a job unless a blank is held
   bre_front #(
      .NUM_STOPS   (NUM_STOPS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req),
      .q_status  (q_status),
      .push      (push),
      .cmd       (push_cmd)
   );

   // job queue between the two halves
   bre_fifo #(
      .WIDTH ($bits(bre_pkg::cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (push_cmd),
      .pop    (pop),
      .rdata  (head_cmd),
      .status (q_status)
   );

   // back: expand each job into its blank run and closing byte
   bre_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head_cmd),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

FILE: tb/sv/entab_tb_pkg.sv
package entab_tb_pkg;
   import bre_pkg::*;

   localparam int          NUM_STOPS   = 6;
   localparam int          COLUMN_BITS = 10;
   localparam int unsigned COL_MAX     = (1 << COLUMN_BITS) - 1;
   localparam int          PRINT_CAP   = 40;

   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 last;
   } out_byte_type;

   class entab_scoreboard;
      logic [WIDTH_BITS-1:0]  stop_count;
      logic [WIDTH_BITS-1:0]  tab_log2;
      logic [STOP_BITS-1:0]   stops [NUM_STOPS];
      logic [COLUMN_BITS-1:0] column;
      logic [PEND_BITS-1:0]   held_blanks;
      out_byte_type           expected_bytes [$];
      int                     errors;
      int                     chars_in;
      int                     bytes_out;

      function new();
         stop_count = RESET_STOP_COUNT;
         tab_log2   = RESET_TAB_WIDTH;
         for (int i = 0; i < NUM_STOPS; i++)
            stops[i] = STOP_BITS'(STOP_SPACING * (i + 1));
         column      = '0;
         held_blanks = '0;
         errors      = 0;
         chars_in    = 0;
         bytes_out   = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index,
                              logic [CSR_DATA_BITS-1:0] value);
         if (index == REG_STOP_COUNT)
            stop_count = value[WIDTH_BITS-1:0];
         else if (index == REG_TAB_WIDTH)
            tab_log2 = value[WIDTH_BITS-1:0];
         else if (int'(index) >= REG_STOP_BASE && int'(index) < REG_STOP_BASE + NUM_STOPS)
            stops[int'(index) - REG_STOP_BASE] = value[STOP_BITS-1:0];
      endfunction

      // smallest enabled stop above col, else the next default multiple
      function int unsigned tab_stop_after(int unsigned col);
         int unsigned n;
         int unsigned best;
         bit          found;
         n     = (32'(stop_count) > NUM_STOPS) ? NUM_STOPS : 32'(stop_count);
         best  = 0;
         found = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (stops[i] > col && (!found || stops[i] < best)) begin
               best  = 32'(stops[i]);
               found = 1'b1;
            end
         end
         if (!found)
            best = ((col >> tab_log2) + 1) << tab_log2;
         return (best > COL_MAX) ? COL_MAX : best;
      endfunction

      task note_char(logic [CHAR_BITS-1:0] c);
         int unsigned          col;
         int unsigned          nxt;
         logic [CHAR_BITS-1:0] burst [$];
         out_byte_type         item;
         col = 32'(column);
         nxt = tab_stop_after(col);
         chars_in++;
         if (c == CH_BLANK) begin
            if (col + 1 == nxt) begin
               burst.push_back(CH_TAB);
               held_blanks = '0;
            end else if (held_blanks >= PEND_MAX) begin
               burst.push_back(CH_BLANK);
            end else begin
               held_blanks++;
            end
            column = COLUMN_BITS'((col + 1 > COL_MAX) ? COL_MAX : col + 1);
         end else if (c == CH_TAB) begin
            burst.push_back(CH_TAB);
            column      = COLUMN_BITS'(nxt);
            held_blanks = '0;
         end else begin
            repeat (held_blanks) burst.push_back(CH_BLANK);
            held_blanks = '0;
            burst.push_back(c);
            column = COLUMN_BITS'((c == CH_NL) ? 0 :
                                  ((col + 1 > COL_MAX) ? COL_MAX : col + 1));
         end
         foreach (burst[i]) begin
            item.out_char = burst[i];
            item.last     = (i == burst.size() - 1);
            expected_bytes.push_back(item);
         end
      endtask

      task check_byte(logic [CHAR_BITS-1:0] out_char, logic last);
         out_byte_type want;
         bytes_out++;
         if (expected_bytes.size() == 0) begin
            report($sformatf("byte %02h (last %b) arrived with nothing expected",
                             out_char, last));
            return;
         end
         want = expected_bytes.pop_front();
         if (out_char !== want.out_char)
            report($sformatf("out byte %0d: char %02h, expected %02h",
                             bytes_out, out_char, want.out_char));
         if (last !== want.last)
            report($sformatf("out byte %0d: last %b, expected %b",
                             bytes_out, last, want.last));
      endtask

      task report(string what);
         if (errors < PRINT_CAP)
            $display("MISMATCH: %s", what);
         errors++;
      endtask
   endclass

endpackage

FILE: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bre_pkg::*;
   import entab_tb_pkg::*;

   // cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT  = 2000;
   // settle time after the last expected byte
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT     = 14;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // set for the stretch in which neither side idles
   bit steady = 1'b0;
   int quiet_cycles = 0;
   int settings_done = 0;

   entab_scoreboard sb = new();

   bre_req_if req_bus ();
   bre_rsp_if rsp_bus ();

   blank_run_to_tab_entab dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: drop ready now and then, never during the steady stretch.
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Check every byte the block hands over against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_byte(rsp_bus.out_char, rsp_bus.last);
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one character, idling first at random, and hold it until the
   // transfer. Valid stays high on return so back-to-back items need no
   // second assignment in the same step.
   task automatic send_char(input logic [CHAR_BITS-1:0] c);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_char <= c;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_char(c);
   endtask

   // Drop valid and wait until every expected byte has come out, then let
   // the pipeline settle so that a register write finds the block idle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   // Write the whole register file; call only after drain.
   task automatic apply_setting(input logic [CSR_DATA_BITS-1:0] count,
                                input logic [CSR_DATA_BITS-1:0] width_code,
                                input logic [CSR_DATA_BITS-1:0] stop_list [NUM_STOPS]);
      write_reg(REG_STOP_COUNT, count);
      write_reg(REG_TAB_WIDTH, width_code);
      for (int i = 0; i < NUM_STOPS; i++)
         write_reg(CSR_INDEX_BITS'(REG_STOP_BASE + i), stop_list[i]);
      csr_we <= 1'b0;
      settings_done++;
   endtask

   // Text-like stream: words, blank runs (some long enough to fill the
   // blank store), tabs, newlines at nl_pct and raw bytes as noise.
   task automatic send_text(input int n_items, input int nl_pct, input int long_pct);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            len = $urandom_range(1, 8);
            repeat (len) send_char(CHAR_BITS'($urandom_range(8'h21, 8'h7E)));
            sent += len;
         end else if (pick < 70) begin
            len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(40, 72)
                                                    : $urandom_range(1, 12);
            repeat (len) send_char(CH_BLANK);
            sent += len;
         end else if (pick < 82) begin
            send_char(CH_TAB);
            sent++;
         end else if (pick < 82 + nl_pct) begin
            send_char(CH_NL);
            sent++;
         end else begin
            send_char(CHAR_BITS'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] stop_list [NUM_STOPS];
      logic [CHAR_BITS-1:0]     directed [$];

      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.in_char <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, at reset settings (default stops every eight columns):
      // held blanks, a blank landing on a stop, a flush before a byte, a
      // tab dropping held blanks, byte extremes and a newline.
      directed = {8'h61, CH_BLANK, CH_BLANK, CH_BLANK, CH_BLANK, CH_BLANK, CH_BLANK,
                  CH_BLANK, CH_BLANK, CH_BLANK, CH_BLANK, 8'h78, CH_BLANK, CH_TAB,
                  8'h00, 8'hFF, 8'h80, 8'h7F, CH_NL};
      foreach (directed[i]) send_char(directed[i]);
      drain();

      // All six stops, ascending, lowest stop at 1; spacing of four beyond.
      stop_list = '{10'd1, 10'd9, 10'd20, 10'd33, 10'd50, 10'd70};
      apply_setting(10'd6, 10'd2, stop_list);
      send_text(50, 8, 5);
      drain();

      // Count above the number of stops, unordered list with a zero stop
      // and one at the top column; spacing of one puts a stop on every column.
      stop_list = '{10'd40, 10'd0, 10'd12, 10'd1023, 10'd6, 10'd25};
      apply_setting(10'd7, 10'd0, stop_list);
      send_text(40, 5, 5);
      drain();

      // No explicit stops, width code seven: long blank runs fill the
      // store, then tabs drive the column into saturation and stay there.
      stop_list = '{10'd100, 10'd200, 10'd300, 10'd400, 10'd500, 10'd600};
      apply_setting(10'd0, 10'd7, stop_list);
      send_char(CH_NL);
      send_text(40, 2, 40);
      repeat (9) send_char(CH_TAB);
      send_text(60, 0, 30);
      drain();

      // Stops near the top column with a spacing of sixty-four beyond.
      stop_list = '{10'd1023, 10'd1000, 10'd700, 10'd5, 10'd5, 10'd5};
      apply_setting(10'd3, 10'd6, stop_list);
      send_char(CH_NL);
      send_text(25, 3, 10);
      repeat (2) send_char(CH_TAB);
      send_text(30, 0, 10);
      drain();

      // Random settings, upper data bits of the narrow registers included.
      repeat (2) begin
         foreach (stop_list[i])
            stop_list[i] = ($urandom_range(0, 3) == 0) ? CSR_DATA_BITS'($urandom_range(0, 1023))
                                                      : CSR_DATA_BITS'($urandom_range(1, 80));
         apply_setting(CSR_DATA_BITS'($urandom_range(0, 1023)),
                       CSR_DATA_BITS'($urandom_range(0, 1023)), stop_list);
         send_text(40, 6, 10);
         drain();
      end

      // Steady stretch: neither side idles.
      foreach (stop_list[i]) stop_list[i] = CSR_DATA_BITS'($urandom_range(1, 80));
      apply_setting(CSR_DATA_BITS'($urandom_range(0, 7)),
                    CSR_DATA_BITS'($urandom_range(0, 7)), stop_list);
      steady = 1'b1;
      send_text(100, 5, 10);
      drain();
      steady = 1'b0;

      $display("Sent %0d characters under %0d register settings, checked %0d output bytes",
               sb.chars_in, settings_done + 1, sb.bytes_out);
      $display("Covered blank runs held, flushed and tabbed, tab jumps, column saturation");
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bre_pkg.sv
rtl/bre_req_if.sv
rtl/bre_rsp_if.sv
rtl/bre_fifo.sv
rtl/bre_front.sv
rtl/bre_back.sv
rtl/blank_run_to_tab_entab.sv
tb/sv/entab_tb_pkg.sv
tb/sv/tb_top.sv
